// File: rtl/core/wgm_pkg.sv
// ----------------------------------------------------------------------------
// Wildcard glob matcher package
// Shared word modes, command bundle and pattern symbol constants.
// ----------------------------------------------------------------------------
package wgm_pkg;

  // Mode field of an input word.
  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_TEXT   = 2'd1,
    MODE_FINISH = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  // Decoded command for the word being executed this cycle; all flags are
  // low when no word is executed.
  typedef struct packed {
    logic       append;
    logic       text;
    logic       finish;
    logic       clear;
    logic [7:0] symbol;
  } cmd_t;

  localparam logic [7:0] SYM_STAR = 8'h2A;
  localparam logic [7:0] SYM_ANY  = 8'h3F;

endpackage

// File: rtl/core/wgm_pattern_store.sv
// ----------------------------------------------------------------------------
// Wildcard glob matcher pattern store
// Holds the pattern bytes, pattern length, start row and overflow flag.
// ----------------------------------------------------------------------------
module wgm_pattern_store
  import wgm_pkg::*;
#(
  parameter int MAX_PATTERN = 32,
  localparam int LEN_W = $clog2(MAX_PATTERN + 1),
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1,
  localparam int ROW_W = MAX_PATTERN + 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cmd_t                        cmd,
  output logic [MAX_PATTERN-1:0][7:0] pat_bytes,
  output logic [LEN_W-1:0]            pat_len,
  output logic                        pat_full,
  output logic [ROW_W-1:0]            start_row_nxt,
  output logic                        overflow
);

  logic [MAX_PATTERN-1:0][7:0] bytes_r;
  logic [LEN_W-1:0]            len_r, len_nxt;
  logic [ROW_W-1:0]            start_row_r;
  logic                        overflow_r, overflow_nxt;
  logic                        wr_en;

  assign pat_full = (len_r == LEN_W'(MAX_PATTERN));

  // A taken append sets the start row bit just past the old end: a star
  // carries the previous bit forward, any other byte cannot match empty text.
  always_comb begin
    len_nxt       = len_r;
    overflow_nxt  = overflow_r;
    start_row_nxt = start_row_r;
    wr_en         = 1'b0;
    priority if (cmd.clear) begin
      len_nxt       = '0;
      overflow_nxt  = 1'b0;
      start_row_nxt = ROW_W'(1);
    end else if (cmd.append) begin
      if (pat_full) begin
        overflow_nxt = 1'b1;
      end else begin
        len_nxt = len_r + LEN_W'(1);
        wr_en   = 1'b1;
        for (int j = 1; j <= MAX_PATTERN; j++) begin
          if (len_r == LEN_W'(j - 1)) begin
            start_row_nxt[j] = (cmd.symbol == SYM_STAR) && start_row_r[j-1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      overflow_r  <= 1'b0;
      start_row_r <= ROW_W'(1);
    end else begin
      len_r       <= len_nxt;
      overflow_r  <= overflow_nxt;
      start_row_r <= start_row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bytes_r[len_r[IDX_W-1:0]] <= cmd.symbol;
    end
  end

  assign pat_bytes = bytes_r;
  assign pat_len   = len_r;
  assign overflow  = overflow_r;

endmodule

// File: rtl/core/wgm_match_row.sv
// ----------------------------------------------------------------------------
// Wildcard glob matcher match row
// Holds the match row and advances it by one text byte per cycle.
// ----------------------------------------------------------------------------
module wgm_match_row
  import wgm_pkg::*;
#(
  parameter int MAX_PATTERN = 32,
  localparam int LEN_W = $clog2(MAX_PATTERN + 1),
  localparam int ROW_W = MAX_PATTERN + 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cmd_t                        cmd,
  input  logic [MAX_PATTERN-1:0][7:0] pat_bytes,
  input  logic [LEN_W-1:0]            pat_len,
  input  logic                        pat_full,
  input  logic [ROW_W-1:0]            start_row_nxt,
  output logic [ROW_W-1:0]            match_row
);

  logic [ROW_W-1:0] row_r, row_nxt, step_row;
  logic             reload;

  // Positions past the pattern end stay clear. A star position ORs in its
  // left neighbour of the new row, so the stars form a ripple chain.
  always_comb begin
    step_row[0] = 1'b0;
    for (int j = 1; j <= MAX_PATTERN; j++) begin
      if (pat_bytes[j-1] == SYM_STAR) begin
        step_row[j] = (LEN_W'(j) <= pat_len) && (step_row[j-1] || row_r[j]);
      end else begin
        step_row[j] = (LEN_W'(j) <= pat_len) && row_r[j-1] &&
                      ((pat_bytes[j-1] == SYM_ANY) || (pat_bytes[j-1] == cmd.symbol));
      end
    end
  end

  assign reload = cmd.clear || cmd.finish || (cmd.append && !pat_full);

  always_comb begin
    row_nxt = row_r;
    priority if (reload) begin
      row_nxt = start_row_nxt;
    end else if (cmd.text) begin
      row_nxt = step_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= ROW_W'(1);
    end else begin
      row_r <= row_nxt;
    end
  end

  assign match_row = row_r;

endmodule

// File: rtl/core/wildcard_glob_matcher_unit.sv
// ----------------------------------------------------------------------------
// Wildcard glob matcher unit
// Whole-string glob matching of a byte stream against a loaded pattern.
// ----------------------------------------------------------------------------
// Usage: every input word carries a mode and a symbol. Mode append adds the
// symbol to the pattern, mode text feeds one text byte, mode finish ends the
// text and mode clear empties the pattern. In the pattern, '*' matches any
// run of bytes, the empty run included, and '?' matches any single byte.
// Only a finish word produces a result word, carrying the match verdict and
// a flag saying that pattern bytes were dropped since the last clear.
// Both channels use valid and stall; a word moves on a rising edge where
// valid is high and stall is low.
// Timing: a word is registered on acceptance and executed in the following
// cycle, unless a stall holds a finish word; the finish loads the result
// register, which offers the result word. One word is taken every cycle
// while in_stall is low; the limit is the row update, a byte compare per
// pattern position and an OR chain over the star positions.
// Stalling: while the result register is full and stalled, a finish word
// waits in the input register and in_stall rises; other words still run.
// Reset: synchronous, active low. It empties the pattern, clears the
// overflow flag and discards any word in flight. No clearing pass is needed.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher_unit
  import wgm_pkg::*;
#(
  parameter int MAX_PATTERN = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_symbol,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_matched,
  output logic       out_pattern_overflow
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int ROW_W = MAX_PATTERN + 1;

  // Input register.
  logic       item_valid_r, item_valid_nxt;
  logic [1:0] item_mode_r;
  logic [7:0] item_symbol_r;
  mode_t      item_mode;

  // Result register.
  logic out_valid_r, out_valid_nxt;
  logic out_matched_r, out_overflow_r;

  logic in_accept, out_free, item_fire;
  cmd_t cmd;

  logic [MAX_PATTERN-1:0][7:0] pat_bytes;
  logic [LEN_W-1:0]            pat_len;
  logic                        pat_full;
  logic [ROW_W-1:0]            start_row_nxt;
  logic                        overflow;
  logic [ROW_W-1:0]            match_row;

  assign item_mode = mode_t'(item_mode_r);

  // The result register can take a word when it is empty or being drained.
  // Only a finish word needs it; every other word executes unconditionally.
  assign out_free  = !out_valid_r || !out_stall;
  assign item_fire = item_valid_r && ((item_mode != MODE_FINISH) || out_free);
  assign in_stall  = item_valid_r && !item_fire;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    cmd        = '0;
    cmd.symbol = item_symbol_r;
    if (item_fire) begin
      unique case (item_mode)
        MODE_APPEND: cmd.append = 1'b1;
        MODE_TEXT:   cmd.text   = 1'b1;
        MODE_FINISH: cmd.finish = 1'b1;
        MODE_CLEAR:  cmd.clear  = 1'b1;
        default:     cmd        = '0;
      endcase
    end
  end

  always_comb begin
    item_valid_nxt = item_valid_r;
    priority if (in_accept) begin
      item_valid_nxt = 1'b1;
    end else if (item_fire) begin
      item_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_mode_r   <= in_mode;
      item_symbol_r <= in_symbol;
    end
    // The verdict is read from the row before the finish reloads it.
    if (cmd.finish) begin
      out_matched_r  <= match_row[pat_len];
      out_overflow_r <= overflow;
    end
  end

  wgm_pattern_store #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_store (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .pat_bytes     (pat_bytes),
    .pat_len       (pat_len),
    .pat_full      (pat_full),
    .start_row_nxt (start_row_nxt),
    .overflow      (overflow)
  );

  wgm_match_row #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_row (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .pat_bytes     (pat_bytes),
    .pat_len       (pat_len),
    .pat_full      (pat_full),
    .start_row_nxt (start_row_nxt),
    .match_row     (match_row)
  );

  assign out_valid            = out_valid_r;
  assign out_matched          = out_matched_r;
  assign out_pattern_overflow = out_overflow_r;

`ifndef ASSERT_OFF
  // The pattern length never passes the store capacity.
  a_len_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pat_len <= LEN_W'(MAX_PATTERN))
    else $error("pattern length beyond capacity");

  // Bytes can only have been dropped once the store is full.
  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    overflow |-> pat_full)
    else $error("overflow flagged with room left");

  // The empty pattern always matches the empty text.
  a_start_bit0: assert property (@(posedge clk) disable iff (!rst_n)
    start_row_nxt[0])
    else $error("start row lost its first bit");

  // A finish word always yields a result on the following edge.
  a_finish_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("finish word produced no result");
`endif

endmodule
